>>> rtl/core/lai_pkg.sv
// Shared constants, register codes and types for the leaky activity integrator.
package lai_pkg;

    localparam int CHANNELS  = 6;
    localparam int CH_W      = 3;
    localparam int SAMPLE_W  = 10;
    localparam int GAIN_W    = 5;
    localparam int LVL_W     = 15;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;
    localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Fixed lane packing of the register file
    localparam int LANES     = 6;
    localparam int LO_LANES  = 4;
    localparam int SUM_W     = LVL_W + 2;

    // Register reset values
    localparam logic [29:0] GAIN_RST     = 30'd346368330;
    localparam logic [59:0] DAMP_LO_RST  = 60'd140741783453700;
    localparam logic [29:0] DAMP_HI_RST  = 30'd131076;
    localparam logic [59:0] MAX_LO_RST   = 60'd351854458634250000;
    localparam logic [29:0] MAX_HI_RST   = 30'd327690000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN    = 3'd0,
        CFG_DAMP_LO = 3'd1,
        CFG_DAMP_HI = 3'd2,
        CFG_MAX_LO  = 3'd3,
        CFG_MAX_HI  = 3'd4
    } cfg_idx_t;

    // Per-channel limits handed to the update stage
    typedef struct packed {
        logic [LVL_W-1:0] damp;
        logic [LVL_W-1:0] ceil;
    } lane_lim_t;

    // One stored channel entry
    typedef struct packed {
        logic [LVL_W-1:0] prev;
        logic [LVL_W-1:0] level;
    } chan_state_t;

endpackage

>>> rtl/core/lai_cfg_regs.sv
// Configuration register file with per-channel gain and limit lookup.
module lai_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lai_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lai_pkg::CFG_W-1:0]      cfg_data,
    input  logic [lai_pkg::CH_W-1:0]       gain_ch,
    output logic [lai_pkg::GAIN_W-1:0]     gain,
    input  logic [lai_pkg::CH_W-1:0]       lim_ch,
    output lai_pkg::lane_lim_t             lim
);
    import lai_pkg::*;

    logic [29:0] gain_reg;
    logic [59:0] damp_lo_reg;
    logic [29:0] damp_hi_reg;
    logic [59:0] max_lo_reg;
    logic [29:0] max_hi_reg;
    logic [LANES*LVL_W-1:0] damp_all;
    logic [LANES*LVL_W-1:0] max_all;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RST;
            damp_lo_reg <= DAMP_LO_RST;
            damp_hi_reg <= DAMP_HI_RST;
            max_lo_reg  <= MAX_LO_RST;
            max_hi_reg  <= MAX_HI_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GAIN:    gain_reg    <= cfg_data[29:0];
                CFG_DAMP_LO: damp_lo_reg <= cfg_data;
                CFG_DAMP_HI: damp_hi_reg <= cfg_data[29:0];
                CFG_MAX_LO:  max_lo_reg  <= cfg_data;
                CFG_MAX_HI:  max_hi_reg  <= cfg_data[29:0];
                default: ;
            endcase
        end
    end

    assign damp_all = {damp_hi_reg, damp_lo_reg};
    assign max_all  = {max_hi_reg, max_lo_reg};

    // Lane selects; out-of-range channels read as zero
    always_comb begin
        gain = '0;
        lim  = '0;
        if (gain_ch < CH_W'(LANES)) begin
            gain = gain_reg[GAIN_W*gain_ch +: GAIN_W];
        end
        if (lim_ch < CH_W'(LANES)) begin
            lim.damp = damp_all[LVL_W*lim_ch +: LVL_W];
            lim.ceil = max_all[LVL_W*lim_ch +: LVL_W];
        end
    end

endmodule

>>> rtl/core/leaky_activity_integrator_core.sv
// Top level of the leaky activity integrator: channel state memory and update pipeline.
//
// Usage:
//   Input words (s_channel, s_sample) arrive on a valid/ready channel; each
//   produces exactly one result word (m_channel_out, m_activity) on the
//   m_ valid/ready channel, in order.
//   The sample is scaled and the channel entry read from the state memory
//   as the word is taken; the level is updated and the result registered,
//   raising m_valid, when the word leaves the update stage.
//   Throughput is one word per cycle while the receiver keeps up. The state
//   memory is read at accept time and written when the word leaves the
//   update stage; a write-back register forwards the latest entry, so
//   same-channel words may follow back to back.
//   Reset clears all levels and stored samples to zero through per-entry
//   valid flags, so the block is ready as soon as reset is released.
//   When the receiver stalls, the result register holds, the update stage
//   holds one more word, and s_ready drops until the result is taken.
//   Configuration words may be written at any time the block is idle.
//
module leaky_activity_integrator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lai_pkg::CH_W-1:0]       s_channel,
    input  logic [lai_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lai_pkg::CH_W-1:0]       m_channel_out,
    output logic [lai_pkg::LVL_W-1:0]      m_activity,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lai_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lai_pkg::CFG_W-1:0]      cfg_data
);
    import lai_pkg::*;

    // State memory and its valid flags
    chan_state_t            mem [CHANNELS];
    logic [CHANNELS-1:0]    vld_reg;
    chan_state_t            rd_data_reg;
    logic                   rd_vld_reg;

    // Update stage
    logic                   s1_valid_reg;
    logic                   s1_inrange_reg;
    logic [CH_W-1:0]        s1_ch_reg;
    logic [LVL_W-1:0]       s1_scaled_reg;

    // Write-back forwarding
    logic                   wb_valid_reg;
    logic [ADDR_W-1:0]      wb_addr_reg;
    chan_state_t            wb_data_reg;

    // Result register
    logic                   m_valid_reg;
    logic [CH_W-1:0]        m_channel_out_reg;
    logic [LVL_W-1:0]       m_activity_reg;

    logic                   accept;
    logic                   in_range;
    logic                   advance;
    logic                   mem_we;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      s1_addr;
    logic [GAIN_W-1:0]      gain;
    logic [LVL_W-1:0]       scaled_next;
    lane_lim_t              lim;
    chan_state_t            cur;
    chan_state_t            upd;
    logic [LVL_W-1:0]       diff;
    logic signed [SUM_W-1:0] sum;

    lai_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gain_ch   (s_channel),
        .gain      (gain),
        .lim_ch    (s1_ch_reg),
        .lim       (lim)
    );

    // Handshake
    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign in_range = (s_channel < CH_W'(CHANNELS));
    assign rd_addr = s_channel[ADDR_W-1:0];
    assign s1_addr = s1_ch_reg[ADDR_W-1:0];
    assign mem_we  = advance && s1_inrange_reg;

    // Scale at accept: 10x5 product, at most 31713
    assign scaled_next = LVL_W'(s_sample * gain);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ch_reg      <= s_channel;
            s1_inrange_reg <= in_range;
            s1_scaled_reg  <= scaled_next;
        end
    end

    // Memory read at accept, write when the word leaves the update stage
    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we) begin
            mem[s1_addr] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (accept && in_range) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (mem_we) begin
                vld_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // Last write holds the newest entry for its channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else if (mem_we) begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= upd;
        end
    end

    // Entry select: forwarded, read, or reset value
    always_comb begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr)) begin
            cur = wb_data_reg;
        end else if (rd_vld_reg) begin
            cur = rd_data_reg;
        end else begin
            cur = '0;
        end
    end

    // Level update with saturation to 0..ceil
    always_comb begin
        diff = (s1_scaled_reg >= cur.prev) ? (s1_scaled_reg - cur.prev)
                                           : (cur.prev - s1_scaled_reg);
        sum  = $signed({2'b00, cur.level}) + $signed({2'b00, diff})
             - $signed({2'b00, lim.damp});
        upd.prev = s1_scaled_reg;
        if (sum < 0) begin
            upd.level = '0;
        end else if (sum[SUM_W-2:0] > {1'b0, lim.ceil}) begin
            upd.level = lim.ceil;
        end else begin
            upd.level = sum[LVL_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_channel_out_reg <= s1_ch_reg;
            m_activity_reg    <= s1_inrange_reg ? upd.level : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_out_reg;
    assign m_activity    = m_activity_reg;

    // Out-of-range channels never report activity
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_channel_out >= CH_W'(CHANNELS)) |-> m_activity == '0)
        else $error("activity reported for out-of-range channel");

    // A memory write always comes from a live in-range word
    a_we_src: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> s1_valid_reg && s1_inrange_reg)
        else $error("state write without a valid in-range word");

    // Forwarding register tracks the last write
    a_wb_track: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> wb_valid_reg && (wb_addr_reg == $past(s1_addr)))
        else $error("write-back register out of step with memory write");

    // Empty pipeline always takes input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input stalled while update stage is empty");

    // A word leaves the update stage only into a free result register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for leaky_activity_integrator_core: directed table, then random words.
module tb;
    import lai_pkg::*;

    localparam int IDLE_PCT      = 31;
    localparam int HOLD_AT       = 300;   // results seen before the long m_ready hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int NARROW_W      = GAIN_W * LANES;   // width of the 30-bit registers
    localparam int CFG_UNUSED_LO = int'(CFG_MAX_HI) + 1;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] act;
    } level_word_t;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        logic                typed;   // act holds a hand-computed level
        logic [LVL_W-1:0]    act;
    } table_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_channel     = '0;
    logic [SAMPLE_W-1:0]  s_sample      = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [CH_W-1:0]      m_channel_out;
    logic [LVL_W-1:0]     m_activity;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;

    // Register copies and channel state of the level predictor
    logic [NARROW_W-1:0]  gain_copy    = GAIN_RST;
    logic [CFG_W-1:0]     damp_lo_copy = DAMP_LO_RST;
    logic [NARROW_W-1:0]  damp_hi_copy = DAMP_HI_RST;
    logic [CFG_W-1:0]     max_lo_copy  = MAX_LO_RST;
    logic [NARROW_W-1:0]  max_hi_copy  = MAX_HI_RST;
    logic [LVL_W-1:0]     prev_scaled [LANES] = '{default: '0};
    logic [LVL_W-1:0]     chan_level  [LANES] = '{default: '0};

    level_word_t pending_levels [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    bit          calm         = 1'b0;   // no idling on either side while set

    // Opening rows; levels typed in where they follow directly from reset values
    table_row_t opening_rows [16] = '{
        '{3'd0, 10'd0,    1'b1, 15'd0},      // underflow after reset
        '{3'd0, 10'd1023, 1'b1, 15'd10000},  // clamps at the default ceiling
        '{3'd0, 10'd1023, 1'b1, 15'd9996},   // no change, damping only
        '{3'd6, 10'd1023, 1'b1, 15'd0},      // channel out of range
        '{3'd7, 10'd0,    1'b1, 15'd0},
        '{3'd5, 10'd1023, 1'b1, 15'd10000},
        '{3'd5, 10'd0,    1'b1, 15'd10000},  // falling step also saturates
        '{3'd1, 10'd3,    1'b1, 15'd26},
        '{3'd1, 10'd3,    1'b1, 15'd22},
        '{3'd2, 10'd512,  1'b1, 15'd5116},
        '{3'd3, 10'd700,  1'b0, 15'd0},
        '{3'd4, 10'd1,    1'b0, 15'd0},
        '{3'd4, 10'd1023, 1'b0, 15'd0},
        '{3'd3, 10'd0,    1'b0, 15'd0},
        '{3'd2, 10'd511,  1'b0, 15'd0},
        '{3'd0, 10'd341,  1'b0, 15'd0}
    };

    leaky_activity_integrator_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_activity    (m_activity),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Level predictor: updates the channel state and returns the new level
    function automatic logic [LVL_W-1:0] next_level(input logic [CH_W-1:0] ch,
                                                     input logic [SAMPLE_W-1:0] smp);
        int               c;
        int               prod;
        int               acc;
        logic [LVL_W-1:0] scaled;
        logic [LVL_W-1:0] diff;
        logic [LVL_W-1:0] damp;
        logic [LVL_W-1:0] top_v;
        c = int'(ch);
        if (c >= CHANNELS) return '0;
        prod   = int'(smp) * int'(gain_copy[GAIN_W*c +: GAIN_W]);
        scaled = LVL_W'(prod);
        diff   = (scaled >= prev_scaled[c]) ? scaled - prev_scaled[c]
                                            : prev_scaled[c] - scaled;
        if (c < LO_LANES) begin
            damp  = damp_lo_copy[LVL_W*c +: LVL_W];
            top_v = max_lo_copy[LVL_W*c +: LVL_W];
        end else begin
            damp  = damp_hi_copy[LVL_W*(c-LO_LANES) +: LVL_W];
            top_v = max_hi_copy[LVL_W*(c-LO_LANES) +: LVL_W];
        end
        acc = int'(chan_level[c]) + int'(diff) - int'(damp);
        if (acc < 0)
            acc = 0;
        else if (acc > int'(top_v))
            acc = int'(top_v);
        prev_scaled[c] = scaled;
        chan_level[c]  = LVL_W'(acc);
        return chan_level[c];
    endfunction

    // Offer one input word with a random lead-in gap; predict once accepted
    task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                             input logic typed, input logic [LVL_W-1:0] typed_act);
        int               gap;
        logic [LVL_W-1:0] act;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        do @(posedge aclk); while (!s_ready);
        act = next_level(ch, smp);
        pending_levels.push_back('{ch: ch, act: typed ? typed_act : act});
    endtask

    // Random words: mostly valid channels, some out of range, extremes of the sample
    task automatic send_random(input int n);
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        int                  pick;
        repeat (n) begin
            if ($urandom_range(99) < 8)
                ch = CH_W'($urandom_range((1 << CH_W) - 1, CHANNELS));
            else
                ch = CH_W'($urandom_range(CHANNELS - 1));
            pick = $urandom_range(9);
            if (pick == 0)
                smp = '0;
            else if (pick == 1)
                smp = '1;
            else
                smp = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            send_word(ch, smp, 1'b0, '0);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
    endtask

    // One register write; leaves cfg_valid high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GAIN:    gain_copy    = data[NARROW_W-1:0];
            CFG_DAMP_LO: damp_lo_copy = data;
            CFG_DAMP_HI: damp_hi_copy = data[NARROW_W-1:0];
            CFG_MAX_LO:  max_lo_copy  = data;
            CFG_MAX_HI:  max_hi_copy  = data[NARROW_W-1:0];
            default: ;
        endcase
    endtask

    // Full register load, junk in the unused upper bits, plus one write to an unused index
    task automatic load_regs(input logic [NARROW_W-1:0] g, input logic [CFG_W-1:0] dl,
                             input logic [NARROW_W-1:0] dh, input logic [CFG_W-1:0] ml,
                             input logic [NARROW_W-1:0] mh);
        cfg_write(CFG_GAIN, CFG_W'({$urandom, g}));
        cfg_write(CFG_DAMP_LO, dl);
        cfg_write(CFG_DAMP_HI, CFG_W'({$urandom, dh}));
        cfg_write(CFG_MAX_LO, ml);
        cfg_write(CFG_MAX_HI, CFG_W'({$urandom, mh}));
        cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_UNUSED_LO)),
                  CFG_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge aclk) begin
        level_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_levels.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result word ch %0d level %0d",
                             $time, m_channel_out, m_activity);
                mismatches++;
            end else begin
                exp_w = pending_levels.pop_front();
                if (m_channel_out !== exp_w.ch || m_activity !== exp_w.act) begin
                    if (mismatches < 10)
                        $display("%0t: mismatch, expected ch %0d level %0d, got ch %0d level %0d",
                                 $time, exp_w.ch, exp_w.act, m_channel_out, m_activity);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off, none while calm
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus
    initial begin
        logic [NARROW_W-1:0] g;
        logic [NARROW_W-1:0] dh;
        logic [NARROW_W-1:0] mh;
        logic [CFG_W-1:0]    dl;
        logic [CFG_W-1:0]    ml;
        logic [LVL_W-1:0]    lane_d;
        logic [LVL_W-1:0]    lane_m;
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows on reset values
        foreach (opening_rows[i])
            send_word(opening_rows[i].ch, opening_rows[i].smp,
                      opening_rows[i].typed, opening_rows[i].act);
        wait_drained();

        // full gain, no damping, top ceiling
        load_regs('1, '0, '0, '1, '1);
        send_random(40);
        wait_drained();

        // full damping, zero ceiling: levels pinned at zero
        load_regs('1, '1, '1, '0, '0);
        send_random(30);
        wait_drained();

        // zero gain: only the stored sample's decay matters
        load_regs('0, {LO_LANES{15'd3}}, {2{15'd3}}, '1, '1);
        send_random(20);
        wait_drained();

        // random settings, phase by phase
        for (int p = 0; p < 7; p++) begin
            for (int k = 0; k < LANES; k++) begin
                g[GAIN_W*k +: GAIN_W] = GAIN_W'($urandom_range((1 << GAIN_W) - 1));
                lane_d = ($urandom_range(3) == 0) ? LVL_W'($urandom)
                                                  : LVL_W'($urandom_range(400));
                lane_m = ($urandom_range(4) == 0) ? {LVL_W{1'b1}} : LVL_W'($urandom);
                if (k < LO_LANES) begin
                    dl[LVL_W*k +: LVL_W] = lane_d;
                    ml[LVL_W*k +: LVL_W] = lane_m;
                end else begin
                    dh[LVL_W*(k-LO_LANES) +: LVL_W] = lane_d;
                    mh[LVL_W*(k-LO_LANES) +: LVL_W] = lane_m;
                end
            end
            load_regs(g, dl, dh, ml, mh);
            calm = (p == 2);
            if (p == 4) begin
                // sender pauses until the pipe is empty, then resumes
                send_random(50);
                wait_drained();
                send_random(60);
            end else begin
                send_random(110);
            end
            calm = 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_levels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
